// File: hw/rtl/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and saturating helpers for the client frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LEN_W   = 64;
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned CNT_W   = 3;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [7:0] PONG_B0  = 8'h8A;
  localparam logic [7:0] PONG_B1  = 8'h00;

  localparam logic CFG_PONG_EN  = 1'b0;
  localparam logic CFG_CLOSE_EN = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_HALTED  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_PONG   = 2'd2,
    KIND_BUFFER = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        opcode;
    logic [LEN_W-1:0]  payload_length;
    logic [3:0]        header_length;
    logic              close_notify;
    logic [7:0]        pong_byte;
    logic [LEN_W-1:0]  consumed_total;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    result_t [SLOTS-1:0]  slot;
  } batch_t;

  localparam result_t RESULT_ZERO = '0;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] a);
    return (&a) ? a : a + LEN_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Walks frame headers one byte per transfer, counts the payload down and
// builds the batch of results that each byte causes.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       buffer_last,
  input  wire logic       pong_en,
  input  wire logic       close_en,
  output batch_t          batch
);

  phase_t           phase_r, phase_nxt;
  logic [3:0]       op_r, op_nxt;
  logic             mask_r, mask_nxt;
  logic [3:0]       hbc_r, hbc_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] bc_r, bc_nxt;
  // Byte count of the current frame including the byte now being parsed.
  logic [LEN_W-1:0] fb_r, fb_nxt;
  logic [2:0]       ml_r, ml_nxt;

  logic [6:0]       len7;
  logic [LEN_W-1:0] acc_shift;
  logic             ext_end, mask_end, pay_end, sec_short, fin, is_close, pong;
  logic [LEN_W-1:0] len_new, fb_now, sum;
  logic [3:0]       hbc_now;
  result_t          r_frame, r_pong0, r_pong1, r_buf;

  assign len7      = data_byte[6:0];
  assign acc_shift = {acc_r[LEN_W-9:0], data_byte};
  assign ext_end   = (phase_r == PH_EXT16 && hbc_r == 4'd3) ||
                     (phase_r == PH_EXT64 && hbc_r == 4'd9);
  assign mask_end  = (ml_r[2:1] == 2'b00);
  assign pay_end   = (rem_r[LEN_W-1:1] == '0);
  assign sec_short = (len7 != LEN_EXT16) && (len7 != LEN_EXT64);

  always_comb begin
    case (phase_r)
      PH_SECOND:          len_new = sec_short ? LEN_W'(len7) : '0;
      PH_EXT16, PH_EXT64: len_new = acc_shift;
      default:            len_new = acc_r;
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_SECOND:          fin = sec_short && !data_byte[7] && (len7 == 7'd0);
      PH_EXT16, PH_EXT64: fin = ext_end && !mask_r && (acc_shift == '0);
      PH_MASK:            fin = mask_end && (acc_r == '0);
      PH_PAYLOAD:         fin = pay_end;
      default:            fin = 1'b0;
    endcase
  end

  assign is_close = (op_r == OP_CLOSE);
  assign pong     = fin && !is_close && (op_r == OP_PING) && pong_en;
  assign fb_now   = (phase_r == PH_SECOND) ? LEN_W'(2) : fb_r;
  assign sum      = sat_add(bc_r, fb_now);
  assign hbc_now  = (phase_r == PH_SECOND) ? 4'd2 :
                    (phase_r == PH_PAYLOAD) ? hbc_r : hbc_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_FIRST:  phase_nxt = PH_SECOND;
      PH_SECOND: begin
        if (len7 == LEN_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (len7 == LEN_EXT64) begin
          phase_nxt = PH_EXT64;
        end else if (data_byte[7]) begin
          phase_nxt = PH_MASK;
        end else if (len7 != 7'd0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_EXT16, PH_EXT64: begin
        if (ext_end) begin
          if (mask_r) begin
            phase_nxt = PH_MASK;
          end else if (acc_shift != '0) begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        if (mask_end && acc_r != '0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: phase_nxt = PH_PAYLOAD;
      default:    phase_nxt = PH_HALTED;
    endcase
    if (fin) begin
      phase_nxt = is_close ? PH_HALTED : PH_FIRST;
    end
  end

  always_comb begin
    op_nxt   = op_r;
    mask_nxt = mask_r;
    hbc_nxt  = hbc_r;
    acc_nxt  = acc_r;
    ml_nxt   = ml_r;
    fb_nxt   = fb_r;
    rem_nxt  = (phase_r == PH_PAYLOAD) ? rem_r - LEN_W'(rem_r != '0) : len_new;
    case (phase_r)
      PH_FIRST: begin
        op_nxt  = data_byte[3:0];
        hbc_nxt = 4'd1;
        fb_nxt  = LEN_W'(2);
      end
      PH_SECOND: begin
        mask_nxt = data_byte[7];
        ml_nxt   = data_byte[7] ? 3'd4 : 3'd0;
        hbc_nxt  = 4'd2;
        acc_nxt  = len_new;
        fb_nxt   = LEN_W'(3);
      end
      PH_EXT16, PH_EXT64: begin
        acc_nxt = acc_shift;
        hbc_nxt = hbc_now;
        fb_nxt  = sat_inc(fb_r);
      end
      PH_MASK: begin
        hbc_nxt = hbc_now;
        fb_nxt  = sat_inc(fb_r);
        ml_nxt  = (ml_r != 3'd0) ? ml_r - 3'd1 : ml_r;
      end
      PH_PAYLOAD: fb_nxt = sat_inc(fb_r);
      default:    fb_nxt = fb_r;
    endcase
    if (fin) begin
      fb_nxt = LEN_W'(1);
    end
    bc_nxt = buffer_last ? '0 : (fin ? sum : bc_r);

    r_frame                = RESULT_ZERO;
    r_frame.kind           = is_close ? KIND_CLOSE : KIND_FRAME;
    r_frame.opcode         = op_r;
    r_frame.payload_length = len_new;
    r_frame.header_length  = hbc_now;
    r_frame.close_notify   = is_close && close_en;
    r_pong0                = RESULT_ZERO;
    r_pong0.kind           = KIND_PONG;
    r_pong0.pong_byte      = PONG_B0;
    r_pong1                = RESULT_ZERO;
    r_pong1.kind           = KIND_PONG;
    r_pong1.pong_byte      = PONG_B1;
    r_buf                  = RESULT_ZERO;
    r_buf.kind             = KIND_BUFFER;
    r_buf.consumed_total   = fin ? sum : bc_r;

    batch.count   = CNT_W'(fin) + (pong ? CNT_W'(2) : '0) + CNT_W'(buffer_last);
    batch.slot[0] = fin ? r_frame : r_buf;
    batch.slot[1] = pong ? r_pong0 : r_buf;
    batch.slot[2] = r_pong1;
    batch.slot[3] = r_buf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      op_r    <= '0;
      mask_r  <= 1'b0;
      hbc_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      bc_r    <= '0;
      fb_r    <= LEN_W'(1);
      ml_r    <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      hbc_r   <= hbc_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      bc_r    <= bc_nxt;
      fb_r    <= fb_nxt;
      ml_r    <= ml_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wsd_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds the results of one byte and shifts them out one transfer at a time.
// ----------------------------------------------------------------------------
module wsd_result_queue import wsd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire batch_t batch,
  input  wire logic   take,
  output logic        ready,
  output logic        valid,
  output logic        last,
  output result_t     head
);

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  result_t [SLOTS-1:0] slot_r, slot_nxt;

  assign valid = (cnt_r != '0);
  assign last  = (cnt_r == CNT_W'(1));
  assign ready = !valid || (last && take);
  assign head  = slot_r[0];

  always_comb begin
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (load) begin
      cnt_nxt  = batch.count;
      slot_nxt = batch.slot;
    end else if (take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int i = 0; i < SLOTS - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/websocket_client_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket client frame deframer
// Parses client frame headers from a byte stream, skips the payload, and
// reports frames, pong replies and per-buffer byte counts.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      valid / stall     data_byte, buffer_last
//   out_     output     valid / stall     one result per transfer
//   cfg_     input      valid / ready     index, data
//
// Each byte is registered when taken, and its first result is offered in the next cycle.
// A byte with no result lets the next byte follow in the next cycle; a byte with one
// result lets it follow once that result transfers. A byte that causes several results,
// at most four, stalls the input until the last is taken from the single result register
// that serves them one per transfer, so output stalls also stall the input while results remain.
// Reset is synchronous, clears the parser state and the result count, and enables both registers.
// ----------------------------------------------------------------------------
module websocket_client_frame_deframer import wsd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_buffer_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_result_kind,
  output logic [3:0]            out_frame_opcode,
  output logic [LEN_W-1:0]      out_payload_length,
  output logic [3:0]            out_header_length,
  output logic                  out_close_notify,
  output logic [7:0]            out_pong_byte,
  output logic [LEN_W-1:0]      out_consumed_total,
  output logic                  out_last,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic             cfg_data
);

  logic    pong_en_r, close_en_r;
  logic    q_ready, in_fire, out_take;
  batch_t  batch;
  result_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = !q_ready;
  assign in_fire   = in_valid && q_ready;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pong_en_r  <= 1'b1;
      close_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PONG_EN:  pong_en_r  <= cfg_data;
        CFG_CLOSE_EN: close_en_r <= cfg_data;
        default:      pong_en_r  <= pong_en_r;
      endcase
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .data_byte   (in_data_byte),
    .buffer_last (in_buffer_last),
    .pong_en     (pong_en_r),
    .close_en    (close_en_r),
    .batch       (batch)
  );

  wsd_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .batch (batch),
    .take  (out_take),
    .ready (q_ready),
    .valid (out_valid),
    .last  (out_last),
    .head  (head)
  );

  assign out_result_kind    = head.kind;
  assign out_frame_opcode   = head.opcode;
  assign out_payload_length = head.payload_length;
  assign out_header_length  = head.header_length;
  assign out_close_notify   = head.close_notify;
  assign out_pong_byte      = head.pong_byte;
  assign out_consumed_total = head.consumed_total;

endmodule
`default_nettype wire

// File: hw/rtl/wsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the top-level ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
module wsd_checker import wsd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       out_result_kind,
  input wire logic [3:0]       out_header_length,
  input wire logic [7:0]       out_pong_byte,
  input wire logic             out_last
);

  // A stalled result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
    $stable(out_pong_byte) && $stable(out_last))
    else $error("stalled result changed");

  // With no result pending the input is never stalled.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no pending result");

  // The buffer count is always the final result of its byte.
  a_buf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_BUFFER |-> out_last)
    else $error("buffer result not last");

  // The first pong byte is always followed by the second.
  a_pong_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PONG && out_pong_byte == PONG_B0 |-> !out_last)
    else $error("pong reply cut short");

  // Frame reports carry a header of at least two bytes.
  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FRAME || out_result_kind == KIND_CLOSE)
    |-> out_header_length >= 4'd2)
    else $error("frame header length too short");

endmodule

bind websocket_client_frame_deframer wsd_checker u_wsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_kind   (out_result_kind),
  .out_header_length (out_header_length),
  .out_pong_byte     (out_pong_byte),
  .out_last          (out_last)
);
`default_nettype wire
